>>> rtl/core/cbbc_pkg.sv
`default_nettype none
package cbbc_pkg;

  localparam int MAX_DIM = 4096;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = IDX_W + 1;
  localparam int RGB_W   = 24;
  localparam int CFG_W   = DIM_W;
  localparam int CFG_A_W = 2;

  localparam logic [RGB_W-1:0] WHITE_RGB = 24'hff_ffff;

  localparam logic [CFG_A_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_MARGIN       = 2'd2;

  localparam logic [DIM_W-1:0] DIM_MAX  = DIM_W'(MAX_DIM);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_DIM - 1);

  // Tracking results of one frame, with the frame size and margin it used
  typedef struct packed {
    logic             seen;
    logic [IDX_W-1:0] first_row;
    logic [IDX_W-1:0] last_row;
    logic [IDX_W-1:0] min_col;
    logic [IDX_W-1:0] max_col;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [IDX_W-1:0] margin;
  } frame_t;

  // Zero acts as one, anything above the maximum as the maximum
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/content_bounding_box_crop_unit.sv
// Channel | Direction | Handshake         | Payload
// --------+-----------+-------------------+------------------------------------------------
// in_     | input     | in_valid/in_stall | in_pixel_rgb
// out_    | output    | out_valid/out_stall | out_do_crop, out_box_left/top/width/height
// cfg_    | input     | cfg_we            | cfg_index, cfg_wdata
//
// One pixel is taken per cycle while in_stall is low; the tracking registers update at the accepting edge.
// The last pixel of a frame moves the frame summary to a second stage; the box, margin
// and clamp are formed there, and the item enters the out_ result register once it is free.
// rst_n (synchronous) clears the raster position, tracking and valids and restores
// the registers to width 4096, height 4096, margin 0.
// in_stall rises only while a frame summary waits behind a stalled result item.
`default_nettype none
module content_bounding_box_crop_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [cbbc_pkg::RGB_W-1:0]     in_pixel_rgb,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_do_crop,
  output logic [cbbc_pkg::IDX_W-1:0]          out_box_left,
  output logic [cbbc_pkg::IDX_W-1:0]          out_box_top,
  output logic [cbbc_pkg::DIM_W-1:0]          out_box_width,
  output logic [cbbc_pkg::DIM_W-1:0]          out_box_height,
  input  wire logic                           cfg_we,
  input  wire logic [cbbc_pkg::CFG_A_W-1:0]   cfg_index,
  input  wire logic [cbbc_pkg::CFG_W-1:0]     cfg_wdata
);

  // configuration
  logic [cbbc_pkg::DIM_W-1:0] width_r, height_r;
  logic [cbbc_pkg::IDX_W-1:0] margin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= cbbc_pkg::DIM_MAX;
      height_r <= cbbc_pkg::DIM_MAX;
      margin_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cbbc_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        cbbc_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        cbbc_pkg::CFG_MARGIN:       margin_r <= cfg_wdata[cbbc_pkg::IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // tracking stage
  logic [cbbc_pkg::IDX_W-1:0] row_r, col_r, first_r, last_r, min_r, max_r;
  logic                       seen_r;
  logic [cbbc_pkg::IDX_W-1:0] row_nxt, col_nxt, first_nxt, last_nxt, min_nxt, max_nxt;
  logic                       seen_nxt;
  logic [cbbc_pkg::DIM_W-1:0] w_eff, h_eff, col_inc, row_inc;
  logic [cbbc_pkg::IDX_W-1:0] col_cur;
  logic                       in_acc, content, last_col, last_row, frame_end;

  logic                       s2_v_r, s2_v_nxt, s2_adv;
  cbbc_pkg::frame_t           s2_r, s2_nxt;

  assign w_eff    = cbbc_pkg::eff_dim(width_r);
  assign h_eff    = cbbc_pkg::eff_dim(height_r);
  assign in_acc   = in_valid && !in_stall;
  assign content  = (in_pixel_rgb != cbbc_pkg::WHITE_RGB);
  // a column left beyond a narrowed width wraps to the row start
  assign col_cur  = ({1'b0, col_r} >= w_eff) ? '0 : col_r;
  assign col_inc  = {1'b0, col_cur} + cbbc_pkg::DIM_W'(1);
  assign row_inc  = {1'b0, row_r} + cbbc_pkg::DIM_W'(1);
  assign last_col = (col_inc >= w_eff);
  assign last_row = (row_inc >= h_eff);
  assign frame_end = in_acc && last_col && last_row;

  always_comb begin
    seen_nxt  = seen_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    if (content) begin
      seen_nxt = 1'b1;
      last_nxt = row_r;
      if (!seen_r) begin
        first_nxt = row_r;
        min_nxt   = col_cur;
        max_nxt   = col_cur;
      end else begin
        if (col_cur < min_r) min_nxt = col_cur;
        if (col_cur > max_r) max_nxt = col_cur;
      end
    end
    if (!last_col) begin
      col_nxt = col_inc[cbbc_pkg::IDX_W-1:0];
      row_nxt = row_r;
    end else begin
      col_nxt = '0;
      row_nxt = row_inc[cbbc_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || frame_end) begin
      row_r   <= '0;
      col_r   <= '0;
      seen_r  <= 1'b0;
      first_r <= '0;
      last_r  <= '0;
      min_r   <= cbbc_pkg::IDX_LAST;
      max_r   <= '0;
    end else if (in_acc) begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      seen_r  <= seen_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
    end
  end

  // frame summary stage
  logic out_valid_r;

  assign s2_adv   = !out_valid_r || !out_stall;
  assign in_stall = s2_v_r && !s2_adv;

  always_comb begin
    s2_nxt.seen      = seen_nxt;
    s2_nxt.first_row = first_nxt;
    s2_nxt.last_row  = last_nxt;
    s2_nxt.min_col   = min_nxt;
    s2_nxt.max_col   = max_nxt;
    s2_nxt.w         = w_eff;
    s2_nxt.h         = h_eff;
    s2_nxt.margin    = margin_r;
    if (frame_end) begin
      s2_v_nxt = 1'b1;
    end else if (s2_adv) begin
      s2_v_nxt = 1'b0;
    end else begin
      s2_v_nxt = s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_end) begin
      s2_r <= s2_nxt;
    end
  end

  // box forming
  logic [cbbc_pkg::IDX_W-1:0] top, left;
  logic [cbbc_pkg::DIM_W-1:0] bot_sum, right_sum, bottom, right;
  logic                       crop;

  always_comb begin
    top       = (s2_r.first_row >= s2_r.margin) ? s2_r.first_row - s2_r.margin : '0;
    left      = (s2_r.min_col >= s2_r.margin) ? s2_r.min_col - s2_r.margin : '0;
    bot_sum   = {1'b0, s2_r.last_row} + {1'b0, s2_r.margin};
    right_sum = {1'b0, s2_r.max_col} + {1'b0, s2_r.margin};
    bottom    = (bot_sum >= s2_r.h) ? s2_r.h - cbbc_pkg::DIM_W'(1) : bot_sum;
    right     = (right_sum >= s2_r.w) ? s2_r.w - cbbc_pkg::DIM_W'(1) : right_sum;
    crop      = s2_r.seen && (s2_r.first_row != s2_r.last_row)
                && ({1'b0, left} < right) && ({1'b0, top} <= bottom);
  end

  // result register
  logic                       do_crop_r;
  logic [cbbc_pkg::IDX_W-1:0] box_left_r, box_top_r;
  logic [cbbc_pkg::DIM_W-1:0] box_width_r, box_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_v_r && s2_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && s2_adv) begin
      do_crop_r <= crop;
      if (crop) begin
        box_left_r   <= left;
        box_top_r    <= top;
        box_width_r  <= right - {1'b0, left} + cbbc_pkg::DIM_W'(1);
        box_height_r <= bottom - {1'b0, top} + cbbc_pkg::DIM_W'(1);
      end else begin
        box_left_r   <= '0;
        box_top_r    <= '0;
        box_width_r  <= s2_r.w;
        box_height_r <= s2_r.h;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_do_crop    = do_crop_r;
  assign out_box_left   = box_left_r;
  assign out_box_top    = box_top_r;
  assign out_box_width  = box_width_r;
  assign out_box_height = box_height_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s2_v_r && out_valid_r)
    else $error("input stalled with an empty summary stage");

  a_no_content_reset_cols: assert property (@(posedge clk) disable iff (!rst_n)
    !seen_r |-> min_r == cbbc_pkg::IDX_LAST && max_r == '0)
    else $error("column bounds moved without content");

  a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> min_r <= max_r)
    else $error("min column above max column");

  a_crop_box_wide: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_do_crop |-> out_box_width >= cbbc_pkg::DIM_W'(2)
      && out_box_height != '0)
    else $error("crop box narrower than two columns");

  a_nocrop_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_do_crop |-> out_box_left == '0 && out_box_top == '0)
    else $error("no-crop item with a shifted origin");

endmodule
`default_nettype wire

>>> test/crop_box_checker.sv
`timescale 1ns / 1ps
module crop_box_checker (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic                         in_stall,
  input  wire logic [cbbc_pkg::RGB_W-1:0]   in_pixel_rgb,
  input  wire logic                         out_valid,
  input  wire logic                         out_stall,
  input  wire logic                         out_do_crop,
  input  wire logic [cbbc_pkg::IDX_W-1:0]   out_box_left,
  input  wire logic [cbbc_pkg::IDX_W-1:0]   out_box_top,
  input  wire logic [cbbc_pkg::DIM_W-1:0]   out_box_width,
  input  wire logic [cbbc_pkg::DIM_W-1:0]   out_box_height,
  input  wire logic                         cfg_we,
  input  wire logic [cbbc_pkg::CFG_A_W-1:0] cfg_index,
  input  wire logic [cbbc_pkg::CFG_W-1:0]   cfg_wdata,
  output int unsigned                       mismatches,
  output int unsigned                       pending,
  output int unsigned                       boxes_checked
);
  import cbbc_pkg::*;

  typedef struct packed {
    logic             crop;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] top;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } crop_box_t;

  crop_box_t expected_boxes[$];

  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [IDX_W-1:0] margin_reg;
  logic [IDX_W-1:0] row_pos;
  logic [IDX_W-1:0] col_pos;
  logic [IDX_W-1:0] top_row;
  logic [IDX_W-1:0] bottom_row;
  logic [IDX_W-1:0] left_col;
  logic [IDX_W-1:0] right_col;
  logic             content_found;

  // zero counts as one, oversize as the maximum
  function automatic int frame_dim(input logic [DIM_W-1:0] raw);
    if (raw == '0) begin
      return 1;
    end
    if (int'(raw) > MAX_DIM) begin
      return MAX_DIM;
    end
    return int'(raw);
  endfunction

  function automatic int field_diff(input string name, input int unsigned want,
                                    input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic clear_frame();
    row_pos       = '0;
    col_pos       = '0;
    content_found = 1'b0;
    top_row       = '0;
    bottom_row    = '0;
    left_col      = IDX_W'(MAX_DIM - 1);
    right_col     = '0;
  endtask

  task automatic apply_register();
    case (cfg_index)
      CFG_IMAGE_WIDTH: begin
        width_reg = cfg_wdata;
      end
      CFG_IMAGE_HEIGHT: begin
        height_reg = cfg_wdata;
      end
      CFG_MARGIN: begin
        margin_reg = cfg_wdata[IDX_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic track_pixel(input logic [RGB_W-1:0] rgb);
    int        w;
    int        h;
    int        mg;
    int        up;
    int        dn;
    int        lo;
    int        hi;
    crop_box_t box;
    w = frame_dim(width_reg);
    h = frame_dim(height_reg);
    // width shrunk under the current column: wrap within the same row
    if (int'(col_pos) >= w) begin
      col_pos = '0;
    end
    if (rgb != WHITE_RGB) begin
      if (!content_found) begin
        top_row   = row_pos;
        left_col  = col_pos;
        right_col = col_pos;
      end
      content_found = 1'b1;
      bottom_row    = row_pos;
      if (col_pos < left_col) begin
        left_col = col_pos;
      end
      if (col_pos > right_col) begin
        right_col = col_pos;
      end
    end
    if (int'(col_pos) + 1 < w) begin
      col_pos = col_pos + 1'b1;
    end else if (int'(row_pos) + 1 < h) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
    end else begin
      box.crop   = 1'b0;
      box.left   = '0;
      box.top    = '0;
      box.width  = DIM_W'(w);
      box.height = DIM_W'(h);
      if (content_found && top_row != bottom_row) begin
        mg = int'(margin_reg);
        up = int'(top_row) - mg;
        if (up < 0) begin
          up = 0;
        end
        dn = int'(bottom_row) + mg;
        if (dn >= h) begin
          dn = h - 1;
        end
        lo = int'(left_col) - mg;
        if (lo < 0) begin
          lo = 0;
        end
        hi = int'(right_col) + mg;
        if (hi >= w) begin
          hi = w - 1;
        end
        if (lo < hi && up <= dn) begin
          box.crop   = 1'b1;
          box.left   = IDX_W'(lo);
          box.top    = IDX_W'(up);
          box.width  = DIM_W'(hi - lo + 1);
          box.height = DIM_W'(dn - up + 1);
        end
      end
      expected_boxes.push_back(box);
      clear_frame();
    end
  endtask

  task automatic check_box();
    crop_box_t want;
    if (expected_boxes.size() == 0) begin
      $error("unexpected result item: do_crop %0d left %0d top %0d width %0d height %0d",
             out_do_crop, out_box_left, out_box_top, out_box_width, out_box_height);
      mismatches++;
    end else begin
      want = expected_boxes.pop_front();
      mismatches += field_diff("do_crop", want.crop, out_do_crop);
      mismatches += field_diff("box_left", want.left, out_box_left);
      mismatches += field_diff("box_top", want.top, out_box_top);
      mismatches += field_diff("box_width", want.width, out_box_width);
      mismatches += field_diff("box_height", want.height, out_box_height);
      boxes_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_boxes.delete();
      width_reg     = DIM_W'(MAX_DIM);
      height_reg    = DIM_W'(MAX_DIM);
      margin_reg    = '0;
      clear_frame();
      mismatches    = 0;
      boxes_checked = 0;
    end else begin
      // results first, so a pixel taken at this edge cannot satisfy itself
      if (out_valid && !out_stall) begin
        check_box();
      end
      // a register written at this edge only applies from the next pixel
      if (in_valid && !in_stall) begin
        track_pixel(in_pixel_rgb);
      end
      if (cfg_we) begin
        apply_register();
      end
    end
    pending = expected_boxes.size();
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import cbbc_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RANDOM_PIXELS   = 1650;

  // index with no register behind it
  localparam logic [CFG_A_W-1:0] CFG_SPARE = 2'd3;

  logic               clk;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic [RGB_W-1:0]   in_pixel_rgb = '0;
  logic               out_stall    = 1'b0;
  logic               cfg_we       = 1'b0;
  logic [CFG_A_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]   cfg_wdata    = '0;

  logic               in_stall;
  logic               out_valid;
  logic               out_do_crop;
  logic [IDX_W-1:0]   out_box_left;
  logic [IDX_W-1:0]   out_box_top;
  logic [DIM_W-1:0]   out_box_width;
  logic [DIM_W-1:0]   out_box_height;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned boxes_checked;

  int unsigned pixels_sent     = 0;
  int unsigned settings_used   = 0;
  int unsigned holds_requested = 0;
  int          frame_w         = MAX_DIM;
  int          frame_h         = MAX_DIM;
  bit          tx_calm         = 1'b0;
  bit          rx_calm         = 1'b0;

  content_bounding_box_crop_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_rgb   (in_pixel_rgb),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_do_crop    (out_do_crop),
    .out_box_left   (out_box_left),
    .out_box_top    (out_box_top),
    .out_box_width  (out_box_width),
    .out_box_height (out_box_height),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  crop_box_checker box_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_rgb   (in_pixel_rgb),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_do_crop    (out_do_crop),
    .out_box_left   (out_box_left),
    .out_box_top    (out_box_top),
    .out_box_width  (out_box_width),
    .out_box_height (out_box_height),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .pending        (pending),
    .boxes_checked  (boxes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : receiver
    int unsigned holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_requested != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !rx_calm && ($urandom_range(99) < 29);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [RGB_W-1:0] random_colour();
    logic [RGB_W-1:0] c;
    case ($urandom_range(3))
      0: c = WHITE_RGB ^ (RGB_W'(1) << $urandom_range(RGB_W - 1));
      1: c = '0;
      default: begin
        do c = RGB_W'($urandom); while (c == WHITE_RGB);
      end
    endcase
    return c;
  endfunction

  task automatic send_pixel(input logic [RGB_W-1:0] rgb);
    if (!tx_calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pixel_rgb <= rgb;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // drain every outstanding box, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(input int raw_w, input int raw_h, input int raw_m);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, CFG_W'(raw_w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_W'(raw_h));
    // top bit of the margin write is dropped by the register
    write_reg(CFG_MARGIN, {1'($urandom_range(1)), IDX_W'(raw_m)});
    frame_w = (raw_w == 0) ? 1 : ((raw_w > MAX_DIM) ? MAX_DIM : raw_w);
    frame_h = (raw_h == 0) ? 1 : ((raw_h > MAX_DIM) ? MAX_DIM : raw_h);
    settings_used++;
  endtask

  task automatic send_frame(input int r0, input int r1, input int c0, input int c1,
                            input int p_in, input int p_out);
    bit in_box;
    for (int r = 0; r < frame_h; r++) begin
      for (int c = 0; c < frame_w; c++) begin
        in_box = (r >= r0) && (r <= r1) && (c >= c0) && (c <= c1);
        if ($urandom_range(99) < (in_box ? p_in : p_out)) begin
          send_pixel(random_colour());
        end else begin
          send_pixel(WHITE_RGB);
        end
      end
    end
  endtask

  task automatic random_frame();
    int pick;
    int r0;
    int r1;
    int c0;
    int c1;
    pick = $urandom_range(9);
    r0 = $urandom_range(frame_h - 1);
    r1 = $urandom_range(frame_h - 1, r0);
    c0 = $urandom_range(frame_w - 1);
    c1 = $urandom_range(frame_w - 1, c0);
    if (pick == 7) begin
      r0 = 0;
      c0 = 0;
    end else if (pick == 8) begin
      r1 = frame_h - 1;
      c1 = frame_w - 1;
    end
    case (pick)
      0: send_frame(r0, r1, c0, c1, 0, 0);
      1: send_frame(r0, r1, c0, c1, 50, 50);
      2: send_frame(r0, r0, c0, c1, 60, 0);
      9: send_frame(r0, r1, c0, c1, 40, 2);
      default: send_frame(r0, r1, c0, c1, 40, 0);
    endcase
  endtask

  initial begin : stimulus
    int unsigned target;
    int          phase;
    int          margin_pick;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // zero sizes act as one: a lone content pixel, single row, no crop
    set_frame(0, 0, 0);
    send_pixel(24'h00_0000);

    set_frame(3, 2, 0);
    send_pixel(WHITE_RGB);
    send_pixel(24'h00_0000);
    send_pixel(WHITE_RGB);
    send_pixel(WHITE_RGB);
    send_pixel(WHITE_RGB);
    send_pixel(24'hff_fffe);

    // widest margin clamps to the whole frame
    set_frame(2, 2, 4095);
    write_reg(CFG_SPARE, CFG_W'($urandom));
    send_pixel(24'h80_0000);
    send_pixel(WHITE_RGB);
    send_pixel(24'h7f_ffff);
    send_pixel(WHITE_RGB);

    // single content column: left equals right
    set_frame(1, 2, 0);
    send_pixel(24'h00_0001);
    send_pixel(24'h00_0000);

    // height cut below the current row ends the frame with top past bottom
    set_frame(2, 4, 0);
    send_pixel(WHITE_RGB);
    send_pixel(WHITE_RGB);
    send_pixel(24'h01_0203);
    send_pixel(WHITE_RGB);
    send_pixel(WHITE_RGB);
    wait_idle();
    write_reg(CFG_IMAGE_HEIGHT, CFG_W'(1));
    send_pixel(24'h0a_0b0c);

    // width cut mid-row wraps the column
    set_frame(4, 2, 0);
    send_pixel(WHITE_RGB);
    send_pixel(24'h00_0000);
    send_pixel(WHITE_RGB);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, CFG_W'(2));
    frame_w = 2;
    send_pixel(24'h55_5555);
    send_pixel(WHITE_RGB);
    send_pixel(WHITE_RGB);
    send_pixel(24'haa_aaaa);

    target = pixels_sent + RANDOM_PIXELS;
    phase  = 0;
    while (pixels_sent < target) begin
      phase++;
      tx_calm = (phase == 6);
      rx_calm = (phase == 6);
      margin_pick = $urandom_range(5);
      if (phase == 3) begin
        // tiny frames so a summary waits behind the held result and the input stalls
        set_frame(2, 2, 0);
        holds_requested++;
        repeat (15) random_frame();
      end else begin
        set_frame($urandom_range(0, 10), $urandom_range(0, 8),
                  (margin_pick == 0) ? 0 :
                  ((margin_pick == 1) ? 4095 : $urandom_range(1, 4)));
        repeat ((phase == 6) ? 25 : $urandom_range(3, 8)) random_frame();
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    // oversized sizes act as the maximum; a later cut wraps the column and ends the frame
    set_frame(8191, 5000, $urandom_range(0, 4));
    repeat (20) send_pixel(random_colour());
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, CFG_W'(8));
    write_reg(CFG_IMAGE_HEIGHT, CFG_W'(3));
    frame_w = 8;
    frame_h = 3;
    repeat (frame_w * frame_h) begin
      send_pixel(($urandom_range(1) == 0) ? random_colour() : WHITE_RGB);
    end

    wait_idle();
    $display("Covered %0d pixels, %0d frame boxes, %0d register settings", pixels_sent,
             boxes_checked, settings_used);
    $display("incl. mid-frame size cuts, a %0d-cycle result hold-off and oversized frames",
             HOLD_OFF_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/cbbc_pkg.sv
rtl/core/content_bounding_box_crop_unit.sv
test/crop_box_checker.sv
test/tb_top.sv
